// ===== hw/rtl/literal_pattern_matcher_defines.svh =====
// assertion macros shared by the checker of the literal pattern matcher
// each macro expects clk_i and rst_ni to be visible where it is used
`ifndef LITERAL_PATTERN_MATCHER_DEFINES_SVH
`define LITERAL_PATTERN_MATCHER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define LPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lpm_pkg.sv =====
// shared types and constants of the literal pattern matcher
// used by lpm_cell and literal_pattern_matcher; no dependencies
package lpm_pkg;

  localparam int unsigned MODE_W     = 3;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned PAT_WORDS  = 4;
  localparam int unsigned PAT_BYTES  = 32;
  localparam int unsigned PAT_IDX_W  = 5;

  typedef enum logic [MODE_W-1:0] {
    MATCH_EXACT     = 3'd1,
    MATCH_PREFIX    = 3'd2,
    MATCH_SUFFIX    = 3'd3,
    MATCH_SUBSTRING = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATCH_MODE = 3'd0,
    CFG_PAT_LENGTH = 3'd1,
    CFG_PAT_WORD0  = 3'd2,
    CFG_PAT_WORD1  = 3'd3,
    CFG_PAT_WORD2  = 3'd4,
    CFG_PAT_WORD3  = 3'd5
  } cfg_idx_e;

  // per-word control broadcast to every window cell
  typedef struct packed {
    logic shift;  // a subject byte enters the window
    logic clear;  // subject ends, window returns to zero
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/lpm_cell.sv =====
// one window cell of the literal pattern matcher: holds one recent byte
// and compares it with its aligned pattern byte; uses lpm_pkg
module lpm_cell
  import lpm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] target_i,
  input  logic       active_i,
  output logic [7:0] byte_o,
  output logic       hit_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;
  logic [7:0] win;

  // window content as seen after this word's byte
  assign win    = ctrl_i.shift ? byte_i : byte_q;
  assign byte_d = ctrl_i.clear ? 8'h00 : win;
  assign hit_o  = !active_i || (win == target_i);
  assign byte_o = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else begin
      byte_q <= byte_d;
    end
  end

endmodule

// ===== hw/rtl/literal_pattern_matcher.sv =====
// top level of the literal pattern matcher: config registers, window chain,
// subject flags and result buffer; uses lpm_pkg and lpm_cell
//
// usage:
//   s_axis carries one subject byte per word: tdata = the byte, tuser = byte
//   present, tlast = end of subject; a word with tuser low and tlast high
//   closes an empty subject, a word with both low changes nothing
//   m_axis carries one word per subject, on the word with tlast set;
//   tdata bit 0 = matched, upper bits zero
//   cfg channel writes register cfg_index_i (0 mode, 1 length, 2..5
//   pattern words) with cfg_data_i; it is always ready, unused indexes drop
// throughput: one input word per cycle while s_axis_tready_o is high; the window compare runs
//   in parallel across PATTERN_MAX cells that shift every accepted byte
// result: the match bit of the closing word is registered into the result buffer
// stall: results queue in a two-entry buffer (output register plus skid);
//   s_axis_tready_o only drops while both entries hold a result
// reset: mode exact, empty pattern, window and flags cleared, no result
//   pending; after each closing word the subject state clears again
module literal_pattern_matcher
  import lpm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [7:0]            s_axis_tdata_i,   // [7:0] data_byte
  input  logic                  s_axis_tuser_i,   // [0] byte_present
  input  logic                  s_axis_tlast_i,   // end_of_subject
  // result stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [7:0]            m_axis_tdata_o,   // [0] matched, [7:1] zero
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // byte count saturates at PATTERN_MAX+1
  localparam int unsigned CntW = $clog2(PATTERN_MAX + 2);
  // common width for length compares
  localparam int unsigned CmpW = (CntW > LEN_W) ? CntW : LEN_W;

  // reads a pattern byte, positions past the stored pattern read as zero
  function automatic logic [7:0] pat_byte(input logic [PAT_BYTES*8-1:0] flat,
                                          input logic [CmpW-1:0] pos);
    logic [PAT_IDX_W-1:0] idx;
    idx = pos[PAT_IDX_W-1:0];
    if (pos >= CmpW'(PAT_BYTES)) begin
      return 8'h00;
    end
    return flat[idx*8 +: 8];
  endfunction

  // configuration registers
  logic [MODE_W-1:0]                    mode_q;
  logic [LEN_W-1:0]                     len_q;
  logic [PAT_WORDS-1:0][CFG_DATA_W-1:0] pat_word_q;
  logic [PAT_BYTES*8-1:0]               pat_flat;

  // subject state
  logic [CntW-1:0] seen_q, seen_d, seen_inc;
  logic            head_q, head_d;
  logic            found_q, found_d;

  // result buffer
  logic main_v_q, main_v_d, skid_v_q, skid_v_d;
  logic main_q, main_d, skid_q, skid_d;

  logic            in_acc, out_acc, push, res;
  logic            present, last_w;
  logic [CmpW-1:0] used_len, len_ext, seen_cmp, seen_new_cmp;
  logic            tail_ok;
  logic            head_miss;
  cell_ctrl_t      ctrl;

  logic [PATTERN_MAX-1:0][7:0] cell_byte;
  logic [PATTERN_MAX-1:0]      cell_hit;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !skid_v_q;
  assign m_axis_tvalid_o = main_v_q;
  assign m_axis_tdata_o  = {7'b0, main_q};

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = main_v_q && m_axis_tready_i;
  assign present = s_axis_tuser_i;
  assign last_w  = s_axis_tlast_i;
  assign push    = in_acc && last_w;

  assign ctrl.shift = in_acc && present;
  assign ctrl.clear = in_acc && last_w;

  assign pat_flat = pat_word_q;

  // pattern length in force, capped at the window depth
  assign len_ext  = CmpW'(len_q);
  assign used_len = (len_ext > CmpW'(PATTERN_MAX)) ? CmpW'(PATTERN_MAX) : len_ext;

  // window chain: cell k holds the k-th newest byte
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [7:0]      chain_in;
    logic [CmpW-1:0] pos;
    logic            active;

    if (k == 0) begin : g_head
      assign chain_in = s_axis_tdata_i;
    end else begin : g_body
      assign chain_in = cell_byte[k-1];
    end

    // the newest byte lines up with the last pattern byte
    assign active = used_len > CmpW'(k);
    assign pos    = used_len - CmpW'(k + 1);

    lpm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .byte_i   (chain_in),
      .target_i (pat_byte(pat_flat, pos)),
      .active_i (active),
      .byte_o   (cell_byte[k]),
      .hit_o    (cell_hit[k])
    );
  end

  // byte count after this word
  assign seen_inc     = (seen_q == CntW'(PATTERN_MAX + 1)) ? seen_q : seen_q + 1'b1;
  assign seen_d       = present ? seen_inc : seen_q;
  assign seen_cmp     = CmpW'(seen_q);
  assign seen_new_cmp = CmpW'(seen_d);

  // newest used_len bytes equal the pattern
  assign tail_ok = (seen_new_cmp >= used_len) && (&cell_hit);

  // leading byte disagrees with the pattern at its position
  assign head_miss = present && (seen_cmp < used_len) &&
                     (s_axis_tdata_i != pat_byte(pat_flat, seen_cmp));

  assign head_d  = head_q && !head_miss;
  assign found_d = found_q || (present && (used_len != '0) && tail_ok);

  always_comb begin
    case (mode_q)
      MATCH_EXACT:     res = (seen_new_cmp == used_len) && head_d;
      MATCH_PREFIX:    res = (seen_new_cmp >= used_len) && head_d;
      MATCH_SUFFIX:    res = tail_ok;
      MATCH_SUBSTRING: res = (used_len == '0) || found_d;
      default:         res = 1'b0;
    endcase
  end

  // two-entry result buffer, output register first
  always_comb begin
    main_v_d = main_v_q;
    main_d   = main_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (out_acc) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end else begin
        main_v_d = push;
        main_d   = res;
      end
    end else if (push) begin
      if (!main_v_q) begin
        main_v_d = 1'b1;
        main_d   = res;
      end else begin
        skid_v_d = 1'b1;
        skid_d   = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  // subject flags, cleared when a subject closes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      head_q  <= 1'b1;
      found_q <= 1'b0;
    end else if (in_acc) begin
      if (last_w) begin
        seen_q  <= '0;
        head_q  <= 1'b1;
        found_q <= 1'b0;
      end else begin
        seen_q  <= seen_d;
        head_q  <= head_d;
        found_q <= found_d;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MATCH_EXACT;
      len_q      <= '0;
      pat_word_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MATCH_MODE: mode_q        <= cfg_data_i[MODE_W-1:0];
        CFG_PAT_LENGTH: len_q         <= cfg_data_i[LEN_W-1:0];
        CFG_PAT_WORD0:  pat_word_q[0] <= cfg_data_i;
        CFG_PAT_WORD1:  pat_word_q[1] <= cfg_data_i;
        CFG_PAT_WORD2:  pat_word_q[2] <= cfg_data_i;
        CFG_PAT_WORD3:  pat_word_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/lpm_checker.sv =====
// port-level checker of the literal pattern matcher and its bind
// depends on literal_pattern_matcher_defines.svh
`include "literal_pattern_matcher_defines.svh"

module lpm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_last_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_data_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a result only appears after a closing word
  `LPM_ASSERT_NOW(a_result_needs_end, $rose(out_valid_i), $past(in_acc && in_last_i), "result without closing word")
  // input only stalls while a result is waiting
  `LPM_ASSERT_NOW(a_stall_needs_result, !in_ready_i, out_valid_i, "input stalled with empty output")
  // a word that does not close the subject makes no result
  `LPM_ASSERT_NEXT(a_no_spurious, in_acc && !in_last_i && !out_valid_i, !out_valid_i, "result from open subject")
  // stalled result holds
  `LPM_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "stalled result changed")

endmodule

bind literal_pattern_matcher lpm_checker u_lpm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (s_axis_tvalid_i),
  .in_ready_i  (s_axis_tready_o),
  .in_last_i   (s_axis_tlast_i),
  .out_valid_i (m_axis_tvalid_o),
  .out_ready_i (m_axis_tready_i),
  .out_data_i  (m_axis_tdata_o)
);

// ===== tb/sv/tb.sv =====
// self-checking testbench of literal_pattern_matcher: streams subject strings
// against changing pattern setups and checks each match word; needs lpm_pkg
// and the matcher rtl, nothing else
module tb;
  import lpm_pkg::*;

  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned ITEM_TARGET   = 1250;
  // mode codes outside the defined set
  localparam logic [MODE_W-1:0] MODE_NONE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TOP  = 3'd7;

  // predicts the match bit of every subject from the accepted words
  class match_scoreboard;
    logic [MODE_W-1:0]     mode;
    logic [LEN_W-1:0]      pat_len;
    logic [CFG_DATA_W-1:0] pat_word [PAT_WORDS];
    logic [7:0]            recent [PAT_BYTES];
    int unsigned           seen;
    bit                    head_ok;
    bit                    found;
    bit                    match_q [$];
    int                    errors;

    function new();
      mode    = MATCH_EXACT;
      pat_len = '0;
      foreach (pat_word[i]) pat_word[i] = '0;
      errors  = 0;
      clear_subject();
    endfunction

    function void clear_subject();
      foreach (recent[i]) recent[i] = '0;
      seen    = 0;
      head_ok = 1'b1;
      found   = 1'b0;
    endfunction

    function int unsigned used_len();
      return (pat_len > PAT_BYTES) ? PAT_BYTES : pat_len;
    endfunction

    function logic [7:0] pat_byte(int unsigned pos);
      if (pos >= PAT_BYTES) return 8'h00;
      return pat_word[pos / 8][(pos % 8) * 8 +: 8];
    endfunction

    // newest len bytes equal the pattern, oldest of them first
    function bit tail_match(int unsigned len);
      if (seen < len) return 1'b0;
      for (int unsigned k = 0; k < len; k++)
        if (recent[k] != pat_byte(len - 1 - k)) return 1'b0;
      return 1'b1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MATCH_MODE: mode = data[MODE_W-1:0];
        CFG_PAT_LENGTH: pat_len = data[LEN_W-1:0];
        CFG_PAT_WORD0:  pat_word[0] = data;
        CFG_PAT_WORD1:  pat_word[1] = data;
        CFG_PAT_WORD2:  pat_word[2] = data;
        CFG_PAT_WORD3:  pat_word[3] = data;
        default: ;
      endcase
    endfunction

    function void note_input(logic [7:0] b, bit present, bit last);
      int unsigned len;
      bit          m;
      len = used_len();
      if (present) begin
        if (seen < len && b != pat_byte(seen)) head_ok = 1'b0;
        for (int k = PAT_BYTES - 1; k > 0; k--) recent[k] = recent[k-1];
        recent[0] = b;
        if (seen < PAT_BYTES + 1) seen++;
        if (len > 0 && tail_match(len)) found = 1'b1;
      end
      if (last) begin
        case (mode)
          MATCH_EXACT:     m = (seen == len) && head_ok;
          MATCH_PREFIX:    m = (seen >= len) && head_ok;
          MATCH_SUFFIX:    m = tail_match(len);
          MATCH_SUBSTRING: m = (len == 0) || found;
          default:         m = 1'b0;
        endcase
        match_q.push_back(m);
        clear_subject();
      end
    endfunction

    function void check_result(logic [7:0] word);
      bit m;
      if (match_q.size() == 0) begin
        $display("%0t: result word %h arrived with no subject pending", $time, word);
        errors++;
        return;
      end
      m = match_q.pop_front();
      if (word !== {7'b0, m}) begin
        $display("%0t: match word mismatch, expected %h, actual %h", $time, {7'b0, m}, word);
        errors++;
      end
    endfunction

    function int pending();
      return match_q.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [7:0]            s_axis_tdata_i;   // [7:0] data_byte
  logic                  s_axis_tuser_i;   // [0] byte_present
  logic                  s_axis_tlast_i;   // end_of_subject
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [7:0]            m_axis_tdata_o;   // [0] matched, [7:1] zero
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  literal_pattern_matcher u_top (.*);

  match_scoreboard sb = new();

  // stimulus-side copy of the pattern, used to build subjects that hit it
  logic [CFG_DATA_W-1:0] pat_word [PAT_WORDS];
  int unsigned           pat_eff;
  logic [7:0]            alph [2];
  bit                    narrow;
  logic [7:0]            subject_q [$];
  int                    burst_left = 0;
  bit                    gaps_on = 1'b1;
  bit                    hold_req = 1'b0;
  int                    items_sent = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // every handshake is observed here, at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid_i && s_axis_tready_o)
        sb.note_input(s_axis_tdata_i, s_axis_tuser_i, s_axis_tlast_i);
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
    end
  end

  // result side: segments of differing stall styles, plus one long hold-off
  initial begin
    int style;
    int cyc;
    m_axis_tready_i = 1'b0;
    cyc = 0;
    forever begin
      style = $urandom_range(0, 3);
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk_i);
        cyc++;
        if (hold_req) begin
          // long hold-off so the result buffer fills and input stalls
          for (int k = 0; k < HOLD_CYCLES; k++) begin
            m_axis_tready_i <= 1'b0;
            @(negedge clk_i);
          end
          hold_req = 1'b0;
          m_axis_tready_i <= 1'b1;
        end else begin
          case (style)
            0:       m_axis_tready_i <= 1'b1;
            1:       m_axis_tready_i <= 1'($urandom_range(0, 1));
            2:       m_axis_tready_i <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready_i <= (cyc % 5 < 3);
          endcase
        end
      end
    end
  end

  function automatic logic [7:0] fill_byte();
    logic [7:0] b;
    b = narrow ? alph[$urandom_range(0, 1)] : 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] pat_at(int unsigned pos);
    return pat_word[pos / 8][(pos % 8) * 8 +: 8];
  endfunction

  // one input word; bursts of random length separated by random gaps
  task automatic send_word(input logic [7:0] b, input bit present, input bit last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid_i <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= present;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (present || last) items_sent++;
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_all(input logic [MODE_W-1:0] mode, input logic [LEN_W-1:0] len);
    pat_eff = (len > PAT_BYTES) ? PAT_BYTES : len;
    cfg_write(CFG_MATCH_MODE, CFG_DATA_W'(mode));
    cfg_write(CFG_PAT_LENGTH, CFG_DATA_W'(len));
    cfg_write(CFG_PAT_WORD0, pat_word[0]);
    cfg_write(CFG_PAT_WORD1, pat_word[1]);
    cfg_write(CFG_PAT_WORD2, pat_word[2]);
    cfg_write(CFG_PAT_WORD3, pat_word[3]);
  endtask

  // stop sending, wait for every pending match word, then let the block go quiet
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_setup();
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  len;
    int                r;
    int unsigned       eff;
    narrow  = 1'($urandom_range(0, 1));
    alph[0] = 8'($urandom_range(0, 255));
    alph[1] = alph[0] ^ (8'h01 << $urandom_range(0, 7));
    // undefined modes now and then, otherwise one of the four
    if ($urandom_range(0, 15) == 0) mode = MODE_W'($urandom_range(5, 8));
    else mode = MODE_W'($urandom_range(MATCH_EXACT, MATCH_SUBSTRING));
    r = $urandom_range(0, 19);
    if (r == 0) len = '0;
    else if (r <= 2) len = LEN_W'(PAT_BYTES);
    else if (r == 3) len = LEN_W'($urandom_range(PAT_BYTES + 1, 63));
    else if (r <= 8) len = LEN_W'($urandom_range(9, PAT_BYTES - 1));
    else len = LEN_W'($urandom_range(1, 8));
    eff = (len > PAT_BYTES) ? PAT_BYTES : len;
    // bytes past the pattern length are junk the block must ignore
    for (int i = 0; i < PAT_BYTES; i++)
      pat_word[i / 8][(i % 8) * 8 +: 8] =
        (i < eff) ? fill_byte() : 8'($urandom_range(0, 255));
    program_all(mode, len);
  endtask

  function automatic void push_pattern(int unsigned upto);
    for (int unsigned i = 0; i < upto; i++) subject_q.push_back(pat_at(i));
  endfunction

  function automatic void push_filler(int n);
    repeat (n) subject_q.push_back(fill_byte());
  endfunction

  // a subject built around the pattern; close = 0 leaves it open
  task automatic send_subject(input bit close);
    int kind;
    int pos;
    bit end_apart;
    subject_q.delete();
    kind = $urandom_range(0, 7);
    case (kind)
      0: push_pattern(pat_eff);
      1: begin
        push_pattern(pat_eff);
        push_filler($urandom_range(1, 6));
      end
      2: begin
        push_filler($urandom_range(1, 6));
        push_pattern(pat_eff);
      end
      3: begin
        push_filler($urandom_range(0, 6));
        push_pattern(pat_eff);
        push_filler($urandom_range(0, 6));
      end
      4: begin
        // one flipped bit somewhere in the pattern
        push_pattern(pat_eff);
        if (pat_eff > 0) begin
          pos = $urandom_range(0, pat_eff - 1);
          subject_q[pos] = subject_q[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
      end
      5: push_pattern((pat_eff > 0) ? $urandom_range(0, pat_eff - 1) : 0);
      6: push_filler(($urandom_range(0, 3) == 0) ? $urandom_range(30, 70)
                                                 : $urandom_range(0, 10));
      default: begin
        push_pattern(pat_eff);
        push_filler($urandom_range(0, 2));
        push_pattern(pat_eff);
      end
    endcase
    end_apart = ($urandom_range(0, 7) == 0);
    foreach (subject_q[i]) begin
      if ($urandom_range(0, 15) == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_word(subject_q[i], 1'b1,
                close && !end_apart && (i == subject_q.size() - 1));
    end
    if (close && (end_apart || subject_q.size() == 0))
      send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  initial begin
    int phases;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    s_axis_tlast_i  = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_MATCH_MODE;
    cfg_data_i      = '0;
    rst_ni          = 1'b0;
    pat_eff         = 0;
    foreach (pat_word[i]) pat_word[i] = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset setup: exact mode, empty pattern; empty subject matches
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'hFF, 1'b1, 1'b1);
    settle();
    // prefix of one all-ones byte
    pat_word[0] = '1;
    program_all(MATCH_PREFIX, 6'd1);
    send_word(8'hFF, 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b1);
    settle();
    // suffix 00 ff, subject closed by a word without a byte
    pat_word[0] = 64'hFF00;
    program_all(MATCH_SUFFIX, 6'd2);
    send_word(8'hFF, 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hFF, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    settle();
    // empty pattern in substring mode matches anything
    program_all(MATCH_SUBSTRING, 6'd0);
    send_word(8'h5A, 1'b1, 1'b1);
    settle();
    // oversized length is taken as the full pattern
    pat_word[0] = '0;
    program_all(MATCH_SUBSTRING, 6'd63);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b1);
    settle();
    // undefined modes never match
    program_all(MODE_NONE, 6'd0);
    send_word(8'h00, 1'b0, 1'b1);
    settle();
    program_all(MODE_TOP, 6'd0);
    send_word(8'hA5, 1'b1, 1'b1);
    settle();
    // pattern rewritten in the middle of a subject
    pat_word[0] = 64'h3412;
    program_all(MATCH_EXACT, 6'd2);
    send_word(8'h12, 1'b1, 1'b0);
    settle();
    cfg_write(CFG_PAT_WORD0, 64'h9912);
    send_word(8'h99, 1'b1, 1'b1);
    settle();

    phases = 0;
    while (items_sent < ITEM_TARGET) begin
      random_setup();
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(4, 16)) send_subject(1'b1);
      // sometimes the next setup lands in the middle of a subject
      if ($urandom_range(0, 7) == 0) send_subject(1'b0);
      settle();
      if (phases == 0) begin
        // back-to-back short subjects against a stalled result side
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++)
          send_word(8'($urandom_range(0, 255)), (i % 3) != 0, 1'b1);
        settle();
      end
      phases++;
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("literal_pattern_matcher regression: pass");
    end else begin
      $display("literal_pattern_matcher regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("literal_pattern_matcher regression: fail");
    $finish;
  end

endmodule
